>>> hw/rtl/hsv2rgb_pkg.sv
// Shared constants, sector codes and pipeline word types of the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int ColorBits   = 8;
  localparam int HueBits     = 13;
  localparam int SectorSpan  = 960;
  localparam int SectorCount = 6;
  localparam int SectorBits  = $clog2(SectorCount);
  localparam int SpanBits    = $clog2(SectorSpan);
  localparam int HueSectors  = ((1 << HueBits) - 1) / SectorSpan;
  localparam int CountBits   = $clog2(HueSectors + 1);
  localparam int ColorMax    = (1 << ColorBits) - 1;
  localparam int FullBits    = ColorBits + SpanBits;
  localparam int ProdBits    = ColorBits + FullBits;

  // 1.0 scaled by the sector span: the common divisor of p, q and t.
  localparam logic [FullBits-1:0] FullScale = FullBits'(ColorMax * SectorSpan);

  localparam int Lanes = 3;
  localparam int LaneP = 0;
  localparam int LaneQ = 1;
  localparam int LaneT = 2;

  typedef enum logic [SectorBits-1:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueBits-1:0]   hue_angle;
    logic [ColorBits-1:0] saturation;
    logic [ColorBits-1:0] brightness;
  } hsv_in_t;

  typedef struct packed {
    logic [ColorBits-1:0] red;
    logic [ColorBits-1:0] green;
    logic [ColorBits-1:0] blue;
  } rgb_out_t;

  typedef struct packed {
    sector_e              sector;
    logic [SpanBits-1:0]  frac;
    logic [ColorBits-1:0] sat;
    logic [ColorBits-1:0] val;
  } sect_t;

  typedef struct packed {
    sector_e                          sector;
    logic [ColorBits-1:0]             val;
    logic [Lanes-1:0][ProdBits-1:0]   num;
  } num_t;

  typedef struct packed {
    sector_e                          sector;
    logic [ColorBits-1:0]             val;
    logic [Lanes-1:0][ColorBits-1:0]  quo;
  } quo_t;

endpackage

>>> hw/rtl/hsv2rgb_sector.sv
// Hue split into sector and in-sector fraction, one register stage.
module hsv2rgb_sector (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hsv2rgb_pkg::hsv_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hsv2rgb_pkg::sect_t    out_data_o
);
  import hsv2rgb_pkg::*;

  logic [CountBits-1:0] cnt_c;
  logic [HueBits-1:0]   base_c;
  logic [HueBits-1:0]   diff_c;
  logic [CountBits-1:0] wrap_c;
  sect_t                sect_d;
  sect_t                sect_q;
  logic                 vld_q;
  logic                 rdy_c;

  // The span multiples are compared in parallel; the count of those passed is hue / span.
  always_comb begin
    cnt_c = '0;
    for (int k = 1; k <= HueSectors; k++) begin
      if (in_data_i.hue_angle >= HueBits'(k * SectorSpan)) begin
        cnt_c = cnt_c + CountBits'(1);
      end
    end
    base_c = HueBits'(int'(cnt_c) * SectorSpan);
    diff_c = in_data_i.hue_angle - base_c;
    wrap_c = (cnt_c >= CountBits'(SectorCount)) ? cnt_c - CountBits'(SectorCount) : cnt_c;
    sect_d.sector = sector_e'(wrap_c[SectorBits-1:0]);
    sect_d.frac   = diff_c[SpanBits-1:0];
    sect_d.sat    = in_data_i.saturation;
    sect_d.val    = in_data_i.brightness;
  end

  assign rdy_c      = !vld_q || out_ready_i;
  assign in_ready_o = rdy_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_c) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c && in_valid_i) begin
      sect_q <= sect_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = sect_q;

endmodule

>>> hw/rtl/hsv2rgb_scale.sv
// Numerators of p, q and t: saturation products, complement, then scaling by value.
module hsv2rgb_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hsv2rgb_pkg::sect_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hsv2rgb_pkg::num_t   out_data_o
);
  import hsv2rgb_pkg::*;

  typedef struct packed {
    sector_e                        sector;
    logic [ColorBits-1:0]           val;
    logic [Lanes-1:0][FullBits-1:0] term;
  } term_t;

  term_t a_d, a_q, b_d, b_q;
  num_t  c_d, c_q;
  logic  a_vld_q, b_vld_q, c_vld_q;
  logic  a_rdy, b_rdy, c_rdy;

  // p uses the whole span as its fraction, so all three lanes share one divisor.
  always_comb begin
    a_d.sector      = in_data_i.sector;
    a_d.val         = in_data_i.val;
    a_d.term[LaneP] = FullBits'(in_data_i.sat) * FullBits'(SectorSpan);
    a_d.term[LaneQ] = FullBits'(in_data_i.sat) * FullBits'(in_data_i.frac);
    a_d.term[LaneT] = FullBits'(in_data_i.sat)
                    * FullBits'(SpanBits'(SectorSpan) - in_data_i.frac);
  end

  always_comb begin
    b_d = a_q;
    for (int l = 0; l < Lanes; l++) begin
      b_d.term[l] = FullScale - a_q.term[l];
    end
  end

  always_comb begin
    c_d.sector = b_q.sector;
    c_d.val    = b_q.val;
    for (int l = 0; l < Lanes; l++) begin
      c_d.num[l] = ProdBits'(b_q.val) * ProdBits'(b_q.term[l]);
    end
  end

  assign c_rdy      = !c_vld_q || out_ready_i;
  assign b_rdy      = !b_vld_q || c_rdy;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_q <= in_valid_i;
      end
      if (b_rdy) begin
        b_vld_q <= a_vld_q;
      end
      if (c_rdy) begin
        c_vld_q <= b_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      a_q <= a_d;
    end
    if (b_rdy && a_vld_q) begin
      b_q <= b_d;
    end
    if (c_rdy && b_vld_q) begin
      c_q <= c_d;
    end
  end

  assign out_valid_o = c_vld_q;
  assign out_data_o  = c_q;

endmodule

>>> hw/rtl/hsv2rgb_div.sv
// Pipelined restoring division by the fixed full scale, one quotient bit per stage.
module hsv2rgb_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsv2rgb_pkg::num_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsv2rgb_pkg::quo_t  out_data_o
);
  import hsv2rgb_pkg::*;

  typedef struct packed {
    sector_e                         sector;
    logic [ColorBits-1:0]            val;
    logic [Lanes-1:0][ProdBits-1:0]  rem;
    logic [Lanes-1:0][ColorBits-1:0] quo;
  } div_t;

  div_t src   [ColorBits+1];
  logic vld   [ColorBits+1];
  logic rdy   [ColorBits+1];

  assign src[0].sector = in_data_i.sector;
  assign src[0].val    = in_data_i.val;
  assign src[0].rem    = in_data_i.num;
  assign src[0].quo    = '0;
  assign vld[0]        = in_valid_i;
  assign in_ready_o    = rdy[0];
  assign rdy[ColorBits] = out_ready_i;

  // Each numerator is at most value times the divisor, so the quotient fits in a colour code.
  for (genvar g = 0; g < ColorBits; g++) begin : g_bit
    localparam int                  Bit     = ColorBits - 1 - g;
    localparam logic [ProdBits-1:0] Shifted = ProdBits'(FullScale) << Bit;

    div_t nxt_c;
    div_t stg_q;
    logic vld_q;

    always_comb begin
      nxt_c = src[g];
      for (int l = 0; l < Lanes; l++) begin
        if (src[g].rem[l] >= Shifted) begin
          nxt_c.rem[l]      = src[g].rem[l] - Shifted;
          nxt_c.quo[l][Bit] = 1'b1;
        end
      end
    end

    assign rdy[g] = !vld_q || rdy[g+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (rdy[g]) begin
        vld_q <= vld[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[g] && vld[g]) begin
        stg_q <= nxt_c;
      end
    end

    assign src[g+1] = stg_q;
    assign vld[g+1] = vld_q;
  end

  assign out_valid_o       = vld[ColorBits];
  assign out_data_o.sector = src[ColorBits].sector;
  assign out_data_o.val    = src[ColorBits].val;
  assign out_data_o.quo    = src[ColorBits].quo;

endmodule

>>> hw/rtl/hsv_to_rgb_converter.sv
// HSV to RGB converter top level: sector split, scaling, division and output routing.
//
//   Channel | Direction | Handshake            | Word
//   in      | input     | in_valid_i/in_ready_o  | hsv_in_t (hue_angle, saturation, brightness)
//   out     | output    | out_valid_o/out_ready_i | rgb_out_t (red, green, blue)
//
// One word is taken per clock cycle without stalls. The path holds one sector stage,
// three scaling stages, one division stage per quotient bit and the output register;
// only the division pipeline grows with ColorBits. Reset clears only the valid bits.
// A stall holds every occupied stage in place while empty stages ahead of it still
// fill, so no word is dropped or repeated.
module hsv_to_rgb_converter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  hsv2rgb_pkg::hsv_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hsv2rgb_pkg::rgb_out_t out_data_o
);
  import hsv2rgb_pkg::*;

  sect_t    sect_data;
  logic     sect_valid, sect_ready;
  num_t     num_data;
  logic     num_valid, num_ready;
  quo_t     quo_data;
  logic     quo_valid, quo_ready;
  rgb_out_t rgb_d, rgb_q;
  logic     out_vld_q;
  logic [ColorBits-1:0] p_c, q_c, t_c, v_c;

  hsv2rgb_sector u_sector (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (sect_valid),
    .out_ready_i (sect_ready),
    .out_data_o  (sect_data)
  );

  hsv2rgb_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sect_valid),
    .in_ready_o  (sect_ready),
    .in_data_i   (sect_data),
    .out_valid_o (num_valid),
    .out_ready_i (num_ready),
    .out_data_o  (num_data)
  );

  hsv2rgb_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (num_valid),
    .in_ready_o  (num_ready),
    .in_data_i   (num_data),
    .out_valid_o (quo_valid),
    .out_ready_i (quo_ready),
    .out_data_o  (quo_data)
  );

  assign p_c = quo_data.quo[LaneP];
  assign q_c = quo_data.quo[LaneQ];
  assign t_c = quo_data.quo[LaneT];
  assign v_c = quo_data.val;

  // Zero saturation needs no special path: p, q and t all come out equal to value.
  always_comb begin
    unique case (quo_data.sector)
      SecRedYel: rgb_d = '{red: v_c, green: t_c, blue: p_c};
      SecYelGrn: rgb_d = '{red: q_c, green: v_c, blue: p_c};
      SecGrnCyn: rgb_d = '{red: p_c, green: v_c, blue: t_c};
      SecCynBlu: rgb_d = '{red: p_c, green: q_c, blue: v_c};
      SecBluMag: rgb_d = '{red: t_c, green: p_c, blue: v_c};
      SecMagRed: rgb_d = '{red: v_c, green: p_c, blue: q_c};
      default:   rgb_d = '{red: v_c, green: p_c, blue: q_c};
    endcase
  end

  assign quo_ready = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (quo_ready) begin
      out_vld_q <= quo_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (quo_ready && quo_valid) begin
      rgb_q <= rgb_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = rgb_q;

  // With the sink ready, the whole stage chain must be able to move.
  a_ready_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled although the output side is ready");

  // p is the darkest component: its fraction is the whole span.
  a_p_lowest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    quo_valid |-> (p_c <= q_c) && (p_c <= t_c))
    else $error("p exceeds q or t after division");

  // Neither scaled component q nor t may exceed value.
  a_within_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    quo_valid |-> (q_c <= v_c) && (t_c <= v_c))
    else $error("q or t exceeds value after division");

endmodule

>>> verif/hsv_to_rgb_converter_checker.sv
// Checker for the HSV to RGB converter: predicts each colour word and compares the results.
module hsv_to_rgb_converter_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  hsv2rgb_pkg::hsv_in_t  in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  hsv2rgb_pkg::rgb_out_t out_data_i,
  output int                    mismatch_count_o,
  output int                    pending_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import hsv2rgb_pkg::*;

  rgb_out_t expected_rgb[$];
  int       mismatch_count = 0;
  int       pixels_checked = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_o        = expected_rgb.size();
  assign checked_o        = pixels_checked;

  function automatic rgb_out_t convert_pixel(hsv_in_t px);
    longint unsigned m, hue, s, v, frac, span_full, p, q, t;
    sector_e         sec;
    rgb_out_t        rgb;
    m   = ColorMax;
    hue = px.hue_angle;
    s   = px.saturation;
    v   = px.brightness;
    if (s == 0) begin
      rgb.red   = ColorBits'(v);
      rgb.green = ColorBits'(v);
      rgb.blue  = ColorBits'(v);
      return rgb;
    end
    // Hue codes at or past 360 degrees fold back onto the six sectors.
    sec       = sector_e'((hue / SectorSpan) % SectorCount);
    frac      = hue % SectorSpan;
    span_full = m * SectorSpan;
    p = (v * (m - s)) / m;
    q = (v * (span_full - s * frac)) / span_full;
    t = (v * (span_full - s * (SectorSpan - frac))) / span_full;
    case (sec)
      SecRedYel: begin
        rgb = {ColorBits'(v), ColorBits'(t), ColorBits'(p)};
      end
      SecYelGrn: begin
        rgb = {ColorBits'(q), ColorBits'(v), ColorBits'(p)};
      end
      SecGrnCyn: begin
        rgb = {ColorBits'(p), ColorBits'(v), ColorBits'(t)};
      end
      SecCynBlu: begin
        rgb = {ColorBits'(p), ColorBits'(q), ColorBits'(v)};
      end
      SecBluMag: begin
        rgb = {ColorBits'(t), ColorBits'(p), ColorBits'(v)};
      end
      default: begin
        rgb = {ColorBits'(v), ColorBits'(p), ColorBits'(q)};
      end
    endcase
    return rgb;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] colour check: %s", $realtime, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    rgb_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_rgb.push_back(convert_pixel(in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_rgb.size() == 0) begin
          report_mismatch($sformatf("unexpected word r=%0d g=%0d b=%0d",
                                    out_data_i.red, out_data_i.green, out_data_i.blue));
        end else begin
          want = expected_rgb.pop_front();
          pixels_checked++;
          if (out_data_i.red !== want.red) begin
            report_mismatch($sformatf("red %0d, expected %0d", out_data_i.red, want.red));
          end
          if (out_data_i.green !== want.green) begin
            report_mismatch($sformatf("green %0d, expected %0d",
                                      out_data_i.green, want.green));
          end
          if (out_data_i.blue !== want.blue) begin
            report_mismatch($sformatf("blue %0d, expected %0d", out_data_i.blue, want.blue));
          end
        end
      end
    end
  end

endmodule

>>> verif/hsv_to_rgb_converter_test.sv
// Top of the HSV to RGB converter testbench: clock, reset, stimulus and verdict.
module hsv_to_rgb_converter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hsv2rgb_pkg::*;

  localparam int Latency     = ColorBits + 5;
  localparam int CycleLimit  = 200000;
  localparam int RandomWords = 160;

  logic     clk         = 1'b0;
  logic     rst_n       = 1'b0;
  logic     in_valid    = 1'b0;
  logic     in_ready;
  hsv_in_t  in_data     = '0;
  logic     out_valid;
  logic     out_ready   = 1'b0;
  rgb_out_t out_data;

  int mismatch_count;
  int pending;
  int pixels_checked;
  int cycle_count     = 0;
  int pixels_sent     = 0;
  int send_idle_pct   = 15;
  int recv_idle_pct   = 76;

  always #5 clk = ~clk;

  hsv_to_rgb_converter dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  hsv_to_rgb_converter_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending),
    .checked_o        (pixels_checked)
  );

  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Valid stays high from one word to the next unless the sender chooses to idle.
  task automatic send_pixel(input int hue, input int sat, input int val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data.hue_angle  <= HueBits'(hue);
    in_data.saturation <= ColorBits'(sat);
    in_data.brightness <= ColorBits'(val);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_random_pixels(input int count);
    int hue, sat, val, pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        hue = $urandom_range(5759);
      end else if (pick < 88) begin
        hue = $urandom_range(8191, 5760);
      end else begin
        // Land on or next to a sector boundary.
        hue = $urandom_range(5) * SectorSpan + ($urandom_range(1) ? $urandom_range(1)
                                                                   : SectorSpan - 1);
      end
      pick = $urandom_range(99);
      sat  = (pick < 10) ? 0 : (pick < 20) ? ColorMax : (pick < 25) ? 1
                                                       : $urandom_range(ColorMax);
      pick = $urandom_range(99);
      val  = (pick < 5) ? 0 : (pick < 15) ? ColorMax : $urandom_range(ColorMax);
      send_pixel(hue % 8192, sat, val);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sector corners, mid-sector points, grey, black and out-of-range hue codes.
    send_pixel(0, 255, 255);
    send_pixel(0, 0, 128);
    send_pixel(959, 255, 255);
    send_pixel(960, 255, 255);
    send_pixel(1920, 255, 200);
    send_pixel(2880, 255, 200);
    send_pixel(3840, 255, 200);
    send_pixel(4800, 255, 200);
    send_pixel(5759, 255, 255);
    send_pixel(480, 128, 200);
    send_pixel(1440, 128, 200);
    send_pixel(2400, 128, 200);
    send_pixel(3360, 128, 200);
    send_pixel(4320, 128, 200);
    send_pixel(5280, 128, 200);
    send_pixel(5760, 200, 180);
    send_pixel(8191, 255, 255);
    send_pixel(7000, 100, 77);
    send_pixel(100, 1, 255);
    send_pixel(100, 255, 0);
    send_pixel(0, 0, 0);
    send_pixel(8191, 0, 255);

    send_random_pixels(RandomWords);
    send_idle_pct = 76;
    recv_idle_pct = 15;
    send_random_pixels(RandomWords);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_pixels(RandomWords);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (4 * Latency) @(posedge clk);

    $display("Sent %0d pixel words and checked %0d colour words over all six sectors,",
             pixels_sent, pixels_checked);
    $display("grey and out-of-range hues, under three sender and receiver idling mixes.");
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/hsv2rgb_pkg.sv
hw/rtl/hsv2rgb_sector.sv
hw/rtl/hsv2rgb_scale.sv
hw/rtl/hsv2rgb_div.sv
hw/rtl/hsv_to_rgb_converter.sv
verif/hsv_to_rgb_converter_checker.sv
verif/hsv_to_rgb_converter_test.sv
